// File: hdl/njdr_pkg.sv
package njdr_pkg;

  localparam int MAX_JETS_DEF = 64;
  localparam logic [17:0] NO_MATCH_DIST = 18'd256000;
  localparam logic [15:0] PHI_SCALE = 16'd25736;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SQRT,
    ST_CMP,
    ST_FETCH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] jet_energy;
    logic [15:0] jet_pt;
    logic [11:0] eta;
    logic [11:0] phi;
  } cmd_t;

  typedef struct packed {
    logic        matched;
    logic [5:0]  match_index;
    logic [17:0] match_distance;
    logic [16:0] matched_energy;
    logic [16:0] matched_pt;
    logic [11:0] matched_eta;
    logic [11:0] matched_phi;
    logic        overflow;
  } res_t;

endpackage

// File: hdl/njdr_if.sv
interface njdr_cmd_if;
  import njdr_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface njdr_res_if;
  import njdr_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/nearest_jet_delta_r_matcher.sv
// channel | direction | payload
// in      | sink      | op, jet_energy, jet_pt, eta, phi
// out     | source    | matched .. overflow
// Clear and load: done when the engine takes the item; load result valid next cycle.
// Query: per stored jet, a RAM read (SCAN), a bit-serial square root (SQRT) and a
// compare (CMP), then a fetch of the best jet and the result (FETCH, OUT); empty store goes to OUT.
// A two-entry queue in front takes items while the engine works, as long as it has room.
// Synchronous active-low reset empties the store count and queue.
// The engine waits while a result is held on the out side.
module nearest_jet_delta_r_matcher #(
  parameter int MAX_JETS = njdr_pkg::MAX_JETS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  njdr_cmd_if.sink   in_ch,
  njdr_res_if.source out_ch
);
  import njdr_pkg::*;

  njdr_cmd_if q_ch ();

  njdr_queue u_queue (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_ch(q_ch));

  njdr_engine #(.MAX_JETS(MAX_JETS)) u_engine (
    .clk(clk), .rst_n(rst_n), .q_ch(q_ch), .out_ch(out_ch));
endmodule

// File: hdl/njdr_ram.sv
module njdr_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/njdr_queue.sv
module njdr_queue (
  input  logic clk,
  input  logic rst_n,
  njdr_cmd_if.sink   in_ch,
  njdr_cmd_if.source q_ch
);
  import njdr_pkg::*;

  cmd_t       buf_r [2];
  logic [1:0] cnt_r;
  logic       rd_r;
  logic       wr_r;
  logic       push;
  logic       pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready && (op_t'(in_ch.data.op) != OP_NONE);
  assign pop = q_ch.valid && q_ch.ready;
  assign q_ch.valid = (cnt_r != 2'd0);
  assign q_ch.data = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      buf_r[wr_r] <= in_ch.data;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count");
  a_nopop: assert property (@(posedge clk) disable iff (!rst_n) cnt_r == 2'd0 |-> !pop)
    else $error("pop empty");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count step");
endmodule

// File: hdl/njdr_engine.sv
module njdr_engine #(
  parameter int MAX_JETS = njdr_pkg::MAX_JETS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  njdr_cmd_if.sink   q_ch,
  njdr_res_if.source out_ch
);
  import njdr_pkg::*;

  localparam int AW = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
  localparam int CW = $clog2(MAX_JETS + 1);

  state_t st_r, st_nxt;
  logic [CW-1:0] count_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] best_idx_r;
  logic [17:0]   best_r;
  logic          found_r;
  logic [11:0]   qeta_r, qphi_r;
  logic          fetch_r;
  res_t          res_r;
  logic          store_full;

  logic          we;
  logic [AW-1:0] raddr;
  logic [55:0]   rdata;
  logic [55:0]   wdata;

  logic [63:0] x_r, r_r, b_r;
  logic [5:0]  step_r;
  logic [31:0] ae_r, ap_r;

  cmd_t cmd;
  assign cmd = q_ch.data;
  assign wdata = {cmd.jet_energy, cmd.jet_pt, cmd.eta, cmd.phi};
  assign we = (st_r == ST_IDLE) && q_ch.valid && !out_ch.valid
              && (op_t'(cmd.op) == OP_LOAD) && (count_r < CW'(MAX_JETS));
  assign raddr = (st_r == ST_FETCH) ? best_idx_r : idx_r;

  njdr_ram #(.WIDTH(56), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(count_r[AW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rdata));

  logic signed [12:0] deta;
  logic [11:0] dp;
  logic [11:0] deta_mag, dphi_mag;
  logic [63:0] rb;
  logic [17:0] dr_rnd;

  always_comb begin
    deta = $signed({qeta_r[11], qeta_r}) - $signed({rdata[23], rdata[23:12]});
    deta_mag = deta[12] ? 12'(-deta) : deta[11:0];
    dp = qphi_r - rdata[11:0];
    dphi_mag = dp[11] ? 12'(13'd4096 - {1'b0, dp}) : dp;
    rb = r_r + b_r;
    dr_rnd = 18'((r_r + 64'd32768) >> 16);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_ch.valid && !out_ch.valid && op_t'(cmd.op) == OP_QUERY) begin
          st_nxt = (count_r == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN:  st_nxt = fetch_r ? ST_SQRT : ST_SCAN;
      ST_SQRT:  st_nxt = (step_r == 6'd32) ? ST_CMP : ST_SQRT;
      ST_CMP: begin
        if (CW'(idx_r) + CW'(1) >= count_r) begin
          st_nxt = ST_FETCH;
        end else begin
          st_nxt = ST_SCAN;
        end
      end
      ST_FETCH: st_nxt = fetch_r ? ST_OUT : ST_FETCH;
      ST_OUT:   st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  assign q_ch.ready = (st_r == ST_IDLE) && !out_ch.valid;
  logic q_done;
  assign q_done = (st_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      count_r <= '0;
      out_ch.valid <= 1'b0;
      fetch_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (q_ch.valid && q_ch.ready) begin
        if (op_t'(cmd.op) == OP_CLEAR) begin
          count_r <= '0;
        end else if (op_t'(cmd.op) == OP_LOAD) begin
          out_ch.valid <= 1'b1;
          if (we) begin
            count_r <= count_r + CW'(1);
          end
        end
      end
      if (q_done) begin
        out_ch.valid <= 1'b1;
      end
      fetch_r <= (st_r == ST_SCAN || st_r == ST_FETCH) && !fetch_r;
    end
  end

  assign store_full = (count_r >= CW'(MAX_JETS));

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_ch.valid && !out_ch.valid) begin
      qeta_r <= cmd.eta;
      qphi_r <= cmd.phi;
      idx_r <= '0;
      best_r <= NO_MATCH_DIST;
      best_idx_r <= '0;
      found_r <= 1'b0;
      if (q_ch.ready) begin
        res_r <= '{overflow: store_full, default: '0};
      end
    end
    if (st_r == ST_SCAN && fetch_r) begin
      ae_r <= {4'd0, deta_mag, 16'd0};
      ap_r <= {20'd0, dphi_mag} * {16'd0, PHI_SCALE};
      step_r <= 6'd0;
    end
    if (st_r == ST_SQRT) begin
      if (step_r == 6'd0) begin
        x_r <= {32'd0, ae_r} * {32'd0, ae_r};
        r_r <= '0;
        b_r <= 64'd1 << 58;
      end else if (step_r == 6'd1) begin
        x_r <= x_r + {32'd0, ap_r} * {32'd0, ap_r};
      end else if (step_r != 6'd32) begin
        if (x_r >= rb) begin
          x_r <= x_r - rb;
          r_r <= (r_r >> 1) + b_r;
        end else begin
          r_r <= r_r >> 1;
        end
        b_r <= b_r >> 2;
      end
      step_r <= step_r + 6'd1;
    end
    if (st_r == ST_CMP) begin
      if (dr_rnd < best_r) begin
        best_r <= dr_rnd;
        best_idx_r <= idx_r;
        found_r <= 1'b1;
      end
      idx_r <= idx_r + AW'(1);
    end
    if (q_done) begin
      res_r.overflow <= 1'b0;
      if (found_r) begin
        res_r.matched <= 1'b1;
        res_r.match_index <= 6'(best_idx_r);
        res_r.match_distance <= best_r;
        res_r.matched_energy <= {1'b0, rdata[55:40]};
        res_r.matched_pt <= {1'b0, rdata[39:24]};
        res_r.matched_eta <= rdata[23:12];
        res_r.matched_phi <= rdata[11:0];
      end else begin
        res_r.matched <= 1'b0;
        res_r.match_index <= '0;
        res_r.match_distance <= NO_MATCH_DIST;
        res_r.matched_energy <= '1;
        res_r.matched_pt <= '1;
        res_r.matched_eta <= '0;
        res_r.matched_phi <= '0;
      end
    end
  end

  assign out_ch.data = res_r;

  a_count: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(MAX_JETS))
    else $error("count range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !q_ch.ready)
    else $error("ready while busy");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_OUT |=> out_ch.valid)
    else $error("query result lost");
endmodule
